>>> hw/rtl/acm_pkg.sv
// Shared types and constants of the multi-pattern byte matcher.
// Used by acm_ctrl, acm_dp and the top level; depends on nothing.
`default_nettype none

package acm_pkg;

    localparam int MAX_STATES_DEF = 256;
    localparam int ALPHABET_SIZE  = 256;
    localparam int SYM_W          = 8;
    localparam int MAX_PATTERNS   = 32;
    localparam int CMD_W          = 3;
    localparam int PIDX_W         = 5;

    // command codes of an input transaction
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_END    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // datapath operation for the current cycle
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CLR_START,
        OP_CLR_STEP,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_END_RD,
        OP_END_WR,
        OP_BLD_INIT,
        OP_ROOT_RD,
        OP_ROOT_WR,
        OP_Q_RD,
        OP_Q_FAIL,
        OP_Q_OUTF,
        OP_Q_OUTR,
        OP_Q_MERGE,
        OP_ROW_RD,
        OP_ROW_WR,
        OP_BLD_DONE,
        OP_SRCH_RD,
        OP_SRCH_OUT,
        OP_SRCH_HIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic built;
        logic drop;
        logic c_last;
        logic q_empty;
        logic clr_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/acm_dp.sv
// Datapath of the matcher: goto, fail, output-set and queue memories,
// cursors and result registers. Depends on acm_pkg; driven by acm_ctrl.
`default_nettype none

module acm_dp
    import acm_pkg::*;
#(
    parameter int MAX_STATES = MAX_STATES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_stat                     o_stat,
    input  wire logic [SYM_W-1:0]        i_byte_value,
    input  wire logic [PIDX_W-1:0]       i_pattern_index,
    input  wire logic                    i_buffer_start,
    output logic [MAX_PATTERNS-1:0]      o_hit_mask,
    output logic                         o_any_match,
    output logic                         o_table_full
);

    localparam int SW    = $clog2(MAX_STATES);
    localparam int UW    = $clog2(MAX_STATES + 1);
    localparam int AW    = SW + SYM_W;
    localparam int DEPTH = MAX_STATES * ALPHABET_SIZE;

    // memories
    logic [SW:0]             m_goto  [DEPTH];
    logic [SW-1:0]           m_fail  [MAX_STATES];
    logic [MAX_PATTERNS-1:0] m_out   [MAX_STATES];
    logic [SW-1:0]           m_queue [MAX_STATES];

    // control registers
    logic [SW-1:0]  r_ins, r_scur, r_head, r_tail;
    logic [UW-1:0]  r_used;
    logic           r_match, r_drop, r_built;
    logic [SYM_W-1:0] r_c;
    logic [AW-1:0]  r_clr;

    // payload registers
    logic [SYM_W-1:0]        r_sym;
    logic [PIDX_W-1:0]       r_pidx;
    logic                    r_start;
    logic [SW-1:0]           r_r, r_f;
    logic [MAX_PATTERNS-1:0] r_outf, r_hit;
    logic [SW:0]             r_ga, r_gb;
    logic [SW-1:0]           r_fd, r_qd;
    logic [MAX_PATTERNS-1:0] r_od;

    // address and write controls
    logic [AW-1:0]           ga_addr, gb_addr, go_waddr;
    logic                    go_we;
    logic [SW:0]             go_wdata;
    logic                    fl_we;
    logic [SW-1:0]           fl_waddr, fl_wdata;
    logic                    os_we;
    logic [SW-1:0]           os_waddr, os_raddr;
    logic [MAX_PATTERNS-1:0] os_wdata;
    logic                    q_we;

    logic                    ga_present, full, clr_lo, tag_ok;
    logic [SW-1:0]           ga_state, via, new_st, next_st;
    logic [MAX_PATTERNS-1:0] tag_bit;

    assign ga_present = r_ga[SW];
    assign ga_state   = r_ga[SW-1:0];
    assign via        = r_gb[SW] ? r_gb[SW-1:0] : '0;
    assign next_st    = ga_present ? ga_state : '0;
    assign full       = (r_used == UW'(MAX_STATES));
    assign new_st     = r_used[SW-1:0];
    assign clr_lo     = (r_clr < AW'(MAX_STATES));
    assign tag_bit    = MAX_PATTERNS'(1) << r_pidx;
    assign tag_ok     = !r_drop && ({1'b0, r_pidx} < (PIDX_W + 1)'(MAX_PATTERNS));
    assign gb_addr    = {r_f, r_c};

    // select read and write ports for the current operation
    always_comb begin
        ga_addr  = {r_ins, r_sym};
        go_we    = 1'b0;
        go_waddr = r_clr;
        go_wdata = '0;
        fl_we    = 1'b0;
        fl_waddr = new_st;
        fl_wdata = '0;
        os_we    = 1'b0;
        os_waddr = new_st;
        os_wdata = '0;
        os_raddr = r_ins;
        q_we     = 1'b0;
        unique case (i_cmd.op)
            OP_CLR_STEP: begin
                go_we    = 1'b1;
                fl_we    = clr_lo;
                fl_waddr = r_clr[SW-1:0];
                os_we    = clr_lo;
                os_waddr = r_clr[SW-1:0];
            end
            OP_ADD_WR: begin
                go_we    = !ga_present && !full;
                go_waddr = {r_ins, r_sym};
                go_wdata = {1'b1, new_st};
                fl_we    = !ga_present && !full;
                os_we    = !ga_present && !full;
            end
            OP_END_WR: begin
                os_we    = tag_ok;
                os_waddr = r_ins;
                os_wdata = r_od | tag_bit;
            end
            OP_ROOT_RD: ga_addr = {{SW{1'b0}}, r_c};
            OP_ROOT_WR: begin
                go_we    = !ga_present;
                go_waddr = {{SW{1'b0}}, r_c};
                go_wdata = {1'b1, {SW{1'b0}}};
                fl_we    = ga_present;
                fl_waddr = ga_state;
                q_we     = ga_present;
            end
            OP_Q_OUTF: os_raddr = r_fd;
            OP_Q_OUTR: os_raddr = r_r;
            OP_Q_MERGE: begin
                os_we    = 1'b1;
                os_waddr = r_r;
                os_wdata = r_od | r_outf;
            end
            OP_ROW_RD: ga_addr = {r_r, r_c};
            OP_ROW_WR: begin
                go_we    = !ga_present;
                go_waddr = {r_r, r_c};
                go_wdata = {1'b1, via};
                fl_we    = ga_present;
                fl_waddr = ga_state;
                fl_wdata = via;
                q_we     = ga_present;
            end
            OP_SRCH_RD: ga_addr = {(r_start ? {SW{1'b0}} : r_scur), r_sym};
            OP_SRCH_OUT: os_raddr = next_st;
            default: ;
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (go_we) begin
            m_goto[go_waddr] <= go_wdata;
        end
        r_ga <= m_goto[ga_addr];
        r_gb <= m_goto[gb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (fl_we) begin
            m_fail[fl_waddr] <= fl_wdata;
        end
        r_fd <= m_fail[r_qd];
    end

    always_ff @(posedge i_clk) begin
        if (os_we) begin
            m_out[os_waddr] <= os_wdata;
        end
        r_od <= m_out[os_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            m_queue[r_tail] <= ga_state;
        end
        r_qd <= m_queue[r_head];
    end

    // cursors, counters and sticky flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins   <= '0;
            r_scur  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_used  <= UW'(1);
            r_match <= 1'b0;
            r_drop  <= 1'b0;
            r_built <= 1'b0;
            r_c     <= '0;
            r_clr   <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_CLR_START: begin
                    r_clr   <= '0;
                    r_ins   <= '0;
                    r_scur  <= '0;
                    r_used  <= UW'(1);
                    r_match <= 1'b0;
                    r_drop  <= 1'b0;
                    r_built <= 1'b0;
                end
                OP_CLR_STEP: r_clr <= r_clr + AW'(1);
                OP_ADD_WR: begin
                    if (ga_present) begin
                        r_ins <= ga_state;
                    end else if (full) begin
                        r_drop <= 1'b1;
                    end else begin
                        r_ins  <= new_st;
                        r_used <= r_used + UW'(1);
                    end
                end
                OP_END_WR: begin
                    r_drop <= 1'b0;
                    r_ins  <= '0;
                end
                OP_BLD_INIT: begin
                    r_c    <= '0;
                    r_head <= '0;
                    r_tail <= '0;
                end
                OP_ROOT_WR, OP_ROW_WR: begin
                    r_c <= r_c + SYM_W'(1);
                    if (ga_present) begin
                        r_tail <= r_tail + SW'(1);
                    end
                end
                OP_Q_FAIL:   r_head  <= r_head + SW'(1);
                OP_BLD_DONE: r_built <= 1'b1;
                OP_SRCH_RD: begin
                    if (r_start) begin
                        r_match <= 1'b0;
                    end
                end
                OP_SRCH_OUT: r_scur <= next_st;
                OP_SRCH_HIT: begin
                    if (|r_od) begin
                        r_match <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // capture transaction fields, build scratch and results
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_sym   <= i_byte_value;
                r_pidx  <= i_pattern_index;
                r_start <= i_buffer_start;
                r_hit   <= '0;
            end
            OP_Q_FAIL:   r_r    <= r_qd;
            OP_Q_OUTF:   r_f    <= r_fd;
            OP_Q_OUTR:   r_outf <= r_od;
            OP_SRCH_HIT: r_hit  <= r_od;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            o_hit_mask   <= r_hit;
            o_any_match  <= r_match;
            o_table_full <= r_drop;
        end
    end

    assign o_stat.built    = r_built;
    assign o_stat.drop     = r_drop;
    assign o_stat.c_last   = (r_c == {SYM_W{1'b1}});
    assign o_stat.q_empty  = (r_head == r_tail);
    assign o_stat.clr_last = (r_clr == AW'(DEPTH - 1));

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(MAX_STATES))
        else $error("state count beyond table size");
    a_ins_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        UW'(r_ins) < r_used)
        else $error("insert cursor on unallocated state");
    a_scur_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        UW'(r_scur) < r_used)
        else $error("search cursor on unallocated state");
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_Q_FAIL) |-> $past(r_head != r_tail))
        else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> hw/rtl/acm_ctrl.sv
// Controller of the matcher: sequences each transaction, the clearing pass
// and the link build over acm_dp. Depends on acm_pkg.
`default_nettype none

module acm_ctrl
    import acm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [CMD_W-1:0] i_command,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    input  wire t_dp_stat         i_stat,
    output t_dp_cmd               o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR_START,
        ST_CLR_STEP,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_END_RD,
        ST_END_WR,
        ST_BLD_INIT,
        ST_ROOT_RD,
        ST_ROOT_WR,
        ST_Q_RD,
        ST_Q_FAIL,
        ST_Q_OUTF,
        ST_Q_OUTR,
        ST_Q_MERGE,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_BLD_DONE,
        ST_SRCH_RD,
        ST_SRCH_OUT,
        ST_SRCH_HIT,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_reply;
    logic   accept, out_free;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;

    // map state to datapath operation
    always_comb begin
        o_cmd.out_load = (r_state == ST_DONE) && out_free;
        unique case (r_state)
            ST_IDLE:      o_cmd.op = accept ? OP_LOAD : OP_IDLE;
            ST_CLR_START: o_cmd.op = OP_CLR_START;
            ST_CLR_STEP:  o_cmd.op = OP_CLR_STEP;
            ST_ADD_RD:    o_cmd.op = OP_ADD_RD;
            ST_ADD_WR:    o_cmd.op = OP_ADD_WR;
            ST_END_RD:    o_cmd.op = OP_END_RD;
            ST_END_WR:    o_cmd.op = OP_END_WR;
            ST_BLD_INIT:  o_cmd.op = OP_BLD_INIT;
            ST_ROOT_RD:   o_cmd.op = OP_ROOT_RD;
            ST_ROOT_WR:   o_cmd.op = OP_ROOT_WR;
            ST_Q_RD:      o_cmd.op = OP_Q_RD;
            ST_Q_FAIL:    o_cmd.op = OP_Q_FAIL;
            ST_Q_OUTF:    o_cmd.op = OP_Q_OUTF;
            ST_Q_OUTR:    o_cmd.op = OP_Q_OUTR;
            ST_Q_MERGE:   o_cmd.op = OP_Q_MERGE;
            ST_ROW_RD:    o_cmd.op = OP_ROW_RD;
            ST_ROW_WR:    o_cmd.op = OP_ROW_WR;
            ST_BLD_DONE:  o_cmd.op = OP_BLD_DONE;
            ST_SRCH_RD:   o_cmd.op = OP_SRCH_RD;
            ST_SRCH_OUT:  o_cmd.op = OP_SRCH_OUT;
            ST_SRCH_HIT:  o_cmd.op = OP_SRCH_HIT;
            default:      o_cmd.op = OP_IDLE;
        endcase
    end

    // state, reply flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR_START;
            r_reply     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            // drop valid once taken, unless a new result is loaded now
            if (o_out_valid && !i_out_stall && !o_cmd.out_load) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_command)
                            CMD_ADD: r_state <= (i_stat.built || i_stat.drop)
                                                ? ST_DONE : ST_ADD_RD;
                            CMD_END:    r_state <= i_stat.built ? ST_DONE : ST_END_RD;
                            CMD_BUILD:  r_state <= i_stat.built ? ST_DONE : ST_BLD_INIT;
                            CMD_SEARCH: r_state <= ST_SRCH_RD;
                            CMD_CLEAR: begin
                                r_state <= ST_CLR_START;
                                r_reply <= 1'b1;
                            end
                            default:    r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_CLR_START: r_state <= ST_CLR_STEP;
                ST_CLR_STEP: begin
                    if (i_stat.clr_last) begin
                        r_state <= r_reply ? ST_DONE : ST_IDLE;
                        r_reply <= 1'b0;
                    end
                end
                ST_ADD_RD:   r_state <= ST_ADD_WR;
                ST_ADD_WR:   r_state <= ST_DONE;
                ST_END_RD:   r_state <= ST_END_WR;
                ST_END_WR:   r_state <= ST_DONE;
                ST_BLD_INIT: r_state <= ST_ROOT_RD;
                ST_ROOT_RD:  r_state <= ST_ROOT_WR;
                ST_ROOT_WR:  r_state <= i_stat.c_last ? ST_Q_RD : ST_ROOT_RD;
                ST_Q_RD:     r_state <= i_stat.q_empty ? ST_BLD_DONE : ST_Q_FAIL;
                ST_Q_FAIL:   r_state <= ST_Q_OUTF;
                ST_Q_OUTF:   r_state <= ST_Q_OUTR;
                ST_Q_OUTR:   r_state <= ST_Q_MERGE;
                ST_Q_MERGE:  r_state <= ST_ROW_RD;
                ST_ROW_RD:   r_state <= ST_ROW_WR;
                ST_ROW_WR:   r_state <= i_stat.c_last ? ST_Q_RD : ST_ROW_RD;
                ST_BLD_DONE: r_state <= ST_DONE;
                ST_SRCH_RD:  r_state <= ST_SRCH_OUT;
                ST_SRCH_OUT: r_state <= ST_SRCH_HIT;
                ST_SRCH_HIT: r_state <= ST_DONE;
                ST_DONE: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/aho_corasick_multi_pattern_matcher.sv
// Top level of the Aho-Corasick multi-pattern byte matcher.
// Depends on acm_pkg; instantiates acm_ctrl and acm_dp.
//
// Input channel (i_in_valid / o_in_stall): one transaction carries a command
// (add pattern byte, end pattern, build links, search byte, clear all), a
// byte, a pattern index and a buffer-start flag. Output channel
// (o_out_valid / i_out_stall): exactly one result per input transaction,
// holding the hit mask, the sticky any-match bit and the table-full bit.
// One transaction is in work at a time; o_in_stall is high until the
// controller is back in idle. A search byte reads the goto memory, then the
// output set of the next state, before its result is loaded into the output
// register; the next transaction can be accepted in the cycle after that.
// Build walks every state's 256-entry goto row, root included, one entry at
// a time, and handles each queued state's fail link and output set.
// Reset and clear all run a clearing pass over the goto memory (and the
// fail and output-set memories), one entry a cycle, with o_in_stall high.
// A stalled output holds its result; a finished transaction waits in the
// controller until the output register is free.
`default_nettype none

module aho_corasick_multi_pattern_matcher
    import acm_pkg::*;
#(
    parameter int MAX_STATES = MAX_STATES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [CMD_W-1:0]        i_command,
    input  wire logic [SYM_W-1:0]        i_byte_value,
    input  wire logic [PIDX_W-1:0]       i_pattern_index,
    input  wire logic                    i_buffer_start,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [MAX_PATTERNS-1:0]      o_hit_mask,
    output logic                         o_any_match,
    output logic                         o_table_full
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    acm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    acm_dp #(
        .MAX_STATES (MAX_STATES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_byte_value    (i_byte_value),
        .i_pattern_index (i_pattern_index),
        .i_buffer_start  (i_buffer_start),
        .o_hit_mask      (o_hit_mask),
        .o_any_match     (o_any_match),
        .o_table_full    (o_table_full)
    );

endmodule

`default_nettype wire

>>> tb/tb_aho_corasick_multi_pattern_matcher.sv
// Testbench for the Aho-Corasick multi-pattern byte matcher.
// Depends on acm_pkg and aho_corasick_multi_pattern_matcher; self-checking
// against an in-bench trie and fail-link predictor.
`timescale 1ns / 100ps

module tb_aho_corasick_multi_pattern_matcher
    import acm_pkg::*;
;

    localparam int NSTATES   = MAX_STATES_DEF;
    localparam int WDOG_MAX  = 400000;
    localparam logic [CMD_W-1:0] CMD_BAD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BAD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_BAD7 = 3'd7;

    typedef struct packed {
        logic [MAX_PATTERNS-1:0] hit;
        logic                    any;
        logic                    full;
    } t_result;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic [PIDX_W-1:0] pidx;
        logic              bstart;
        bit                known;
        t_result           res;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [CMD_W-1:0]        i_command = '0;
    logic [SYM_W-1:0]        i_byte_value = '0;
    logic [PIDX_W-1:0]       i_pattern_index = '0;
    logic                    i_buffer_start = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [MAX_PATTERNS-1:0] o_hit_mask;
    logic                    o_any_match;
    logic                    o_table_full;

    aho_corasick_multi_pattern_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_command(i_command), .i_byte_value(i_byte_value),
        .i_pattern_index(i_pattern_index), .i_buffer_start(i_buffer_start),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_hit_mask(o_hit_mask), .o_any_match(o_any_match),
        .o_table_full(o_table_full)
    );

    always #5 i_clk = ~i_clk;

    // trie state of the predictor
    int                      trie_next [NSTATES*ALPHABET_SIZE];
    bit                      trie_has  [NSTATES*ALPHABET_SIZE];
    int                      fail_of   [NSTATES];
    logic [MAX_PATTERNS-1:0] tags_of   [NSTATES];
    int                      n_states, ins_at, srch_at;
    bit                      seen_hit, dropped, links_done;

    t_result result_q[$];
    t_row    pending_row;
    bit      row_known;
    int      n_fail, n_items, n_hits, idle_mode, wdog;
    bit      hold_req, hold_done;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        n_fail++;
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function automatic void trie_clear();
        for (int k = 0; k < NSTATES*ALPHABET_SIZE; k++) begin
            trie_next[k] = 0;
            trie_has[k]  = 0;
        end
        for (int s = 0; s < NSTATES; s++) begin
            fail_of[s] = 0;
            tags_of[s] = '0;
        end
        n_states = 1; ins_at = 0; srch_at = 0;
        seen_hit = 0; dropped = 0; links_done = 0;
    endfunction

    // breadth-first pass: fail links, completed goto rows, merged tags
    function automatic void trie_link();
        int q[$];
        int r, f, k, via;
        for (int c = 0; c < ALPHABET_SIZE; c++) begin
            if (!trie_has[c]) begin
                trie_next[c] = 0; trie_has[c] = 1;
            end else begin
                fail_of[trie_next[c]] = 0;
                q = {q, trie_next[c]};
            end
        end
        while (q.size() > 0) begin
            r = q.pop_front();
            f = fail_of[r];
            tags_of[r] |= tags_of[f];
            for (int c = 0; c < ALPHABET_SIZE; c++) begin
                k = r*ALPHABET_SIZE + c;
                via = trie_has[f*ALPHABET_SIZE + c] ? trie_next[f*ALPHABET_SIZE + c] : 0;
                if (!trie_has[k]) begin
                    trie_next[k] = via; trie_has[k] = 1;
                end else begin
                    fail_of[trie_next[k]] = via;
                    q = {q, trie_next[k]};
                end
            end
        end
        links_done = 1;
    endfunction

    function automatic t_result match_step(input logic [CMD_W-1:0] cmd,
                                           input logic [SYM_W-1:0] sym,
                                           input logic [PIDX_W-1:0] pidx,
                                           input logic bstart);
        t_result r;
        int k;
        r.hit = '0;
        case (cmd)
            CMD_ADD: if (!links_done && !dropped) begin
                k = ins_at*ALPHABET_SIZE + sym;
                if (trie_has[k]) ins_at = trie_next[k];
                else if (n_states >= NSTATES) dropped = 1;
                else begin
                    trie_next[k] = n_states; trie_has[k] = 1;
                    fail_of[n_states] = 0; tags_of[n_states] = '0;
                    ins_at = n_states; n_states++;
                end
            end
            CMD_END: if (!links_done) begin
                if (!dropped) tags_of[ins_at][pidx] = 1'b1;
                dropped = 0; ins_at = 0;
            end
            CMD_BUILD: if (!links_done) trie_link();
            CMD_SEARCH: begin
                if (bstart) begin
                    srch_at = 0; seen_hit = 0;
                end
                k = srch_at*ALPHABET_SIZE + sym;
                srch_at = trie_has[k] ? trie_next[k] : 0;
                r.hit = tags_of[srch_at];
                if (r.hit != '0) seen_hit = 1;
            end
            CMD_CLEAR: trie_clear();
            default: ;
        endcase
        r.any = seen_hit;
        r.full = dropped;
        return r;
    endfunction

    // predict on every accepted input, check every accepted result
    always @(posedge i_clk) begin
        t_result want, p;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                p = match_step(i_command, i_byte_value, i_pattern_index, i_buffer_start);
                result_q = {result_q, (row_known ? pending_row.res : p)};
                n_items++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (o_hit_mask != '0) n_hits++;
                if (result_q.size() == 0) report_mismatch("unexpected result", 0, 0);
                else begin
                    want = result_q.pop_front();
                    if (o_hit_mask !== want.hit)
                        report_mismatch("hit_mask", o_hit_mask, want.hit);
                    if (o_any_match !== want.any)
                        report_mismatch("any_match", o_any_match, want.any);
                    if (o_table_full !== want.full)
                        report_mismatch("table_full", o_table_full, want.full);
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) wdog = 0;
            else if (++wdog >= WDOG_MAX) begin
                $display("Watchdog expired with %0d results pending", result_q.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side back-pressure, including one long hold-off
    initial begin
        int pct;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                hold_req = 0;
            end else begin
                pct = (idle_mode == 0) ? 67 : (idle_mode == 1) ? 7 : 0;
                i_out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                        input logic [PIDX_W-1:0] pidx, input logic bstart,
                        input bit known, input t_result res);
        int pct, gap;
        pct = (idle_mode == 0) ? 7 : (idle_mode == 1) ? 67 : 0;
        gap = ($urandom_range(99) < pct) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_command <= cmd; i_byte_value <= sym;
        i_pattern_index <= pidx; i_buffer_start <= bstart;
        row_known = known;
        pending_row.res = res;
        do @(posedge i_clk); while (o_in_stall);
        // advance the idling pattern through its three phases
        idle_mode = (n_items < 600) ? 0 : (n_items < 1200) ? 1 : 2;
        if (n_items >= 700 && !hold_done) begin
            hold_req  = 1;
            hold_done = 1;
        end
    endtask

    task automatic send_rand(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                             input logic [PIDX_W-1:0] pidx, input logic bstart);
        send(cmd, sym, pidx, bstart, 0, '0);
    endtask

    function automatic logic [SYM_W-1:0] pick(input logic [SYM_W-1:0] pool [4]);
        return ($urandom_range(99) < 85) ? pool[$urandom_range(3)] : SYM_W'($urandom);
    endfunction

    t_row dir_rows [$];

    function automatic t_row mk(input logic [CMD_W-1:0] c, input logic [SYM_W-1:0] b,
                                input logic [PIDX_W-1:0] p, input logic s,
                                input bit kn = 0);
        t_row r;
        r.cmd = c; r.sym = b; r.pidx = p; r.bstart = s; r.known = kn; r.res = '0;
        return r;
    endfunction

    initial begin
        logic [SYM_W-1:0] pool [4];
        int npat, plen;
        trie_clear();
        n_fail = 0; n_items = 0; n_hits = 0; idle_mode = 0; wdog = 0;
        hold_req = 0; hold_done = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, bad commands, tagged root, rebuild, clear
        dir_rows = '{
            mk(CMD_SEARCH, 8'h00, 0, 1, 1), mk(CMD_BAD5, 8'hFF, 31, 1, 1),
            mk(CMD_BAD7, 8'h00, 0, 0, 1),
            mk(CMD_ADD, 8'h61, 0, 0), mk(CMD_ADD, 8'h62, 0, 0), mk(CMD_END, 0, 0, 0),
            mk(CMD_ADD, 8'h62, 0, 0), mk(CMD_END, 0, 31, 0),
            mk(CMD_ADD, 8'hFF, 0, 0), mk(CMD_ADD, 8'h00, 0, 0), mk(CMD_END, 0, 5, 0),
            mk(CMD_END, 0, 3, 0), mk(CMD_SEARCH, 8'h61, 0, 1),
            mk(CMD_BUILD, 0, 0, 0), mk(CMD_BUILD, 0, 0, 0),
            mk(CMD_ADD, 8'h61, 0, 0), mk(CMD_END, 0, 1, 0),
            mk(CMD_SEARCH, 8'h61, 0, 1), mk(CMD_SEARCH, 8'h62, 0, 0),
            mk(CMD_SEARCH, 8'hFF, 0, 0), mk(CMD_SEARCH, 8'h00, 0, 0),
            mk(CMD_SEARCH, 8'h00, 0, 1), mk(CMD_BAD6, 8'h5A, 9, 0),
            mk(CMD_CLEAR, 0, 0, 0, 1), mk(CMD_SEARCH, 8'h61, 0, 0, 1)
        };
        foreach (dir_rows[i])
            send(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].pidx,
                 dir_rows[i].bstart, dir_rows[i].known, dir_rows[i].res);

        // random dictionaries over a small alphabet, then streamed text
        for (int seg = 0; seg < 4; seg++) begin
            if (seg > 0)
                send_rand(CMD_CLEAR, SYM_W'($urandom), PIDX_W'($urandom), 1'($urandom));
            for (int j = 0; j < 4; j++) pool[j] = SYM_W'($urandom);
            npat = $urandom_range(4, 10);
            for (int p = 0; p < npat; p++) begin
                plen = $urandom_range(0, 5);
                for (int j = 0; j < plen; j++)
                    send_rand(CMD_ADD, pick(pool), PIDX_W'($urandom), 1'($urandom));
                send_rand(CMD_END, SYM_W'($urandom), PIDX_W'($urandom), 1'($urandom));
            end
            repeat (10) send_rand(CMD_SEARCH, pick(pool), 0, $urandom_range(9) == 0);
            send_rand(CMD_BUILD, SYM_W'($urandom), PIDX_W'($urandom), 1'($urandom));
            for (int j = 0; j < 330; j++) begin
                // hold the sender once until every result is back
                if (seg == 2 && j == 100) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    while (result_q.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(99) < 6)
                    send_rand(CMD_W'($urandom_range(7)), SYM_W'($urandom),
                              PIDX_W'($urandom), 1'($urandom));
                else if ($urandom_range(99) < 1)
                    send_rand(CMD_BUILD, SYM_W'($urandom), PIDX_W'($urandom),
                              1'($urandom));
                else
                    send_rand(CMD_SEARCH, pick(pool), PIDX_W'($urandom),
                              $urandom_range(19) == 0);
            end
        end

        // fill the table with one long pattern, then search the raw trie
        send_rand(CMD_CLEAR, 0, 0, 0);
        for (int j = 0; j < 262; j++) send_rand(CMD_ADD, SYM_W'($urandom), 0, 0);
        send_rand(CMD_END, 0, PIDX_W'($urandom), 0);
        send_rand(CMD_ADD, SYM_W'($urandom), 0, 0);
        send_rand(CMD_END, 0, 7, 0);
        repeat (20) send_rand(CMD_SEARCH, SYM_W'($urandom), 0, $urandom_range(4) == 0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d transactions: directed cases, %0d nonzero hit masks,", n_items, n_hits);
        $display("pre-build and post-build search, table overflow and clear all");
        if (n_fail == 0 && result_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> aho_corasick_multi_pattern_matcher.f
hw/rtl/acm_pkg.sv
hw/rtl/acm_dp.sv
hw/rtl/acm_ctrl.sv
hw/rtl/aho_corasick_multi_pattern_matcher.sv
tb/tb_aho_corasick_multi_pattern_matcher.sv
